// File: rtl/cds_pkg.sv
// ============================================================================
// cds_pkg
// Shared types, constants and calendar helper functions for the date stepper.
// ============================================================================
`default_nettype none

package cds_pkg;

    // Action codes carried by each input transaction
    typedef enum logic [1:0] {
        ACT_LOAD       = 2'd0,
        ACT_NEXT_DAY   = 2'd1,
        ACT_NEXT_MONTH = 2'd2,
        ACT_NEXT_YEAR  = 2'd3
    } t_action;

    typedef logic [13:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_day;

    localparam t_year  YEAR_MIN  = 14'd1;
    localparam t_year  YEAR_MAX  = 14'd9999;
    localparam t_year  DEF_YEAR  = 14'd2021;
    localparam t_month DEF_MONTH = 4'd1;
    localparam t_day   DEF_DAY   = 5'd1;

    localparam t_month MONTH_JAN = 4'd1;
    localparam t_month MONTH_FEB = 4'd2;
    localparam t_month MONTH_DEC = 4'd12;

    // Divide a year by 100: multiply by 5243 / 2^19, exact below 16384
    function automatic logic [7:0] f_div100(input t_year y);
        logic [26:0] p;
        begin
            p = 27'(y) * 27'd5243;
            return p[26:19];
        end
    endfunction

    // Leap year under the 4/100/400 rule
    function automatic logic f_is_leap(input t_year y);
        logic [7:0] q;
        t_year      r;
        begin
            q = f_div100(y);
            r = y - (14'(q) * 14'd100);
            return ((y[1:0] == 2'd0) && (r != 14'd0)) ||
                   ((r == 14'd0) && (q[1:0] == 2'd0));
        end
    endfunction

    // Days in a month; any code outside 1..12 reads as 31
    function automatic t_day f_month_len(input logic leap, input t_month m);
        begin
            unique case (m)
                4'd2:                      return leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
                default:                   return 5'd31;
            endcase
        end
    endfunction

    // Floor(31 * mm / 12) for the shifted month mm (March = 1)
    function automatic t_day f_month_term(input t_month mm);
        begin
            unique case (mm)
                4'd1:    return 5'd2;
                4'd2:    return 5'd5;
                4'd3:    return 5'd7;
                4'd4:    return 5'd10;
                4'd5:    return 5'd12;
                4'd6:    return 5'd15;
                4'd7:    return 5'd18;
                4'd8:    return 5'd20;
                4'd9:    return 5'd23;
                4'd10:   return 5'd25;
                4'd11:   return 5'd28;
                4'd12:   return 5'd31;
                default: return 5'd0;
            endcase
        end
    endfunction

    // Remainder mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [2:0] f_mod7(input logic [14:0] s);
        logic [5:0] x;
        logic [3:0] y;
        begin
            x = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
            y = 4'(x[2:0]) + 4'(x[5:3]);
            return (y >= 4'd7) ? 3'(y - 4'd7) : y[2:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/calendar_date_stepper_core.sv
// ============================================================================
// calendar_date_stepper_core
// Gregorian date register (years 1..9999) with load / next day / next month /
// next year actions and a weekday output.
// ============================================================================
// One transaction is accepted per clock cycle. The held date updates in the
// cycle the transaction is accepted, so back-to-back actions chain directly.
// Each result passes through two result registers: the first register
// holds the updated date and ok flag, the second adds the weekday, computed
// from the date by a Zeller-style sum with a constant divide-by-100 and a
// digit-fold mod 7. Both result registers move as an elastic pipeline, so the
// input stalls only when both are full and the output side is stalling.
// Reset value is 2021-01-01. A rejected load sets 2021-01-01 and clears ok;
// an action that would pass 9999-12-31 leaves the date alone and clears ok.
`default_nettype none

module calendar_date_stepper_core
    import cds_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_action,
    input  wire  [13:0] i_load_year,
    input  wire  [3:0]  i_load_month,
    input  wire  [4:0]  i_load_day,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [13:0] o_cur_year,
    output logic [3:0]  o_cur_month,
    output logic [4:0]  o_cur_day,
    output logic [2:0]  o_weekday,
    output logic        o_ok
);

    // Held date
    t_year  r_held_year;
    t_month r_held_month;
    t_day   r_held_day;
    t_year  n_held_year;
    t_month n_held_month;
    t_day   n_held_day;
    logic   n_ok;

    // First result stage
    logic   r_v1;
    t_year  r_s1_year;
    t_month r_s1_month;
    t_day   r_s1_day;
    logic   r_s1_ok;

    // Second result stage (ports)
    logic   r_v2;
    t_year  r_o_year;
    t_month r_o_month;
    t_day   r_o_day;
    logic [2:0] r_o_weekday;
    logic   r_o_ok;

    logic   en1;
    logic   en2;
    logic   accept;

    // Handshake: advance each stage when it is empty or its consumer moves
    assign en2        = !r_v2 || !i_out_stall;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign accept     = i_in_valid && en1;

    // Leap flags and month lengths used by the actions
    logic   leap_load;
    logic   leap_cur;
    logic   leap_next;
    t_year  year_inc;
    t_day   len_load;
    t_day   len_cur;
    t_day   len_next_month;
    t_day   feb_next_len;
    t_month month_inc;
    logic   load_good;

    assign year_inc       = r_held_year + 14'd1;
    assign month_inc      = r_held_month + 4'd1;
    assign leap_load      = f_is_leap(i_load_year);
    assign leap_cur       = f_is_leap(r_held_year);
    assign leap_next      = f_is_leap(year_inc);
    assign len_load       = f_month_len(leap_load, i_load_month);
    assign len_cur        = f_month_len(leap_cur, r_held_month);
    assign len_next_month = f_month_len(leap_cur, month_inc);
    assign feb_next_len   = f_month_len(leap_next, MONTH_FEB);

    assign load_good = (i_load_year >= YEAR_MIN) && (i_load_year <= YEAR_MAX) &&
                       (i_load_month >= MONTH_JAN) && (i_load_month <= MONTH_DEC) &&
                       (i_load_day != 5'd0) && (i_load_day <= len_load);

    // Compute the date after the requested action
    always_comb begin
        n_held_year  = r_held_year;
        n_held_month = r_held_month;
        n_held_day   = r_held_day;
        n_ok         = 1'b1;
        unique case (t_action'(i_action))
            ACT_LOAD: begin
                if (load_good) begin
                    n_held_year  = i_load_year;
                    n_held_month = i_load_month;
                    n_held_day   = i_load_day;
                end else begin
                    n_held_year  = DEF_YEAR;
                    n_held_month = DEF_MONTH;
                    n_held_day   = DEF_DAY;
                    n_ok         = 1'b0;
                end
            end
            ACT_NEXT_DAY: begin
                if (r_held_day < len_cur) begin
                    n_held_day = r_held_day + 5'd1;
                end else if (r_held_month < MONTH_DEC) begin
                    n_held_day   = 5'd1;
                    n_held_month = month_inc;
                end else if (r_held_year < YEAR_MAX) begin
                    n_held_day   = 5'd1;
                    n_held_month = MONTH_JAN;
                    n_held_year  = year_inc;
                end else begin
                    n_ok = 1'b0;
                end
            end
            ACT_NEXT_MONTH: begin
                if (r_held_month >= MONTH_DEC) begin
                    // January always has room for the held day
                    if (r_held_year >= YEAR_MAX) begin
                        n_ok = 1'b0;
                    end else begin
                        n_held_year  = year_inc;
                        n_held_month = MONTH_JAN;
                    end
                end else begin
                    n_held_month = month_inc;
                    if (r_held_day > len_next_month) begin
                        n_held_day = len_next_month;
                    end
                end
            end
            ACT_NEXT_YEAR: begin
                if (r_held_year >= YEAR_MAX) begin
                    n_ok = 1'b0;
                end else begin
                    n_held_year = year_inc;
                    // February 29 drops to the 28th in a common year
                    if ((r_held_month == MONTH_FEB) && (r_held_day > feb_next_len)) begin
                        n_held_day = feb_next_len;
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Update the held date on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_year  <= DEF_YEAR;
            r_held_month <= DEF_MONTH;
            r_held_day   <= DEF_DAY;
        end else if (accept) begin
            r_held_year  <= n_held_year;
            r_held_month <= n_held_month;
            r_held_day   <= n_held_day;
        end
    end

    // Capture the updated date into the first result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_year  <= n_held_year;
            r_s1_month <= n_held_month;
            r_s1_day   <= n_held_day;
            r_s1_ok    <= n_ok;
        end
    end

    // Weekday: shift the year to start in March, then sum and reduce mod 7
    logic        jan_feb;
    t_year       wd_year;
    t_month      wd_month;
    logic [7:0]  wd_q100;
    logic [14:0] wd_sum;
    logic [2:0]  wd_day;

    assign jan_feb  = (r_s1_month <= MONTH_FEB);
    assign wd_year  = r_s1_year - 14'(jan_feb);
    assign wd_month = jan_feb ? (r_s1_month + 4'd10) : (r_s1_month - 4'd2);
    assign wd_q100  = f_div100(wd_year);
    assign wd_sum   = 15'(r_s1_day) + 15'(wd_year) + 15'(wd_year[13:2])
                    - 15'(wd_q100) + 15'(wd_q100[7:2]) + 15'(f_month_term(wd_month));
    assign wd_day   = f_mod7(wd_sum);

    // Move the first stage into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_o_year    <= r_s1_year;
            r_o_month   <= r_s1_month;
            r_o_day     <= r_s1_day;
            r_o_weekday <= wd_day;
            r_o_ok      <= r_s1_ok;
        end
    end

    assign o_out_valid = r_v2;
    assign o_cur_year  = r_o_year;
    assign o_cur_month = r_o_month;
    assign o_cur_day   = r_o_day;
    assign o_weekday   = r_o_weekday;
    assign o_ok        = r_o_ok;

    // Held date always stays a legal calendar date
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_year >= YEAR_MIN) && (r_held_year <= YEAR_MAX) &&
        (r_held_month >= MONTH_JAN) && (r_held_month <= MONTH_DEC) &&
        (r_held_day != 5'd0) && (r_held_day <= len_cur))
        else $error("held date out of range");

    // Input stalls only when both result stages are full and output stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && i_out_stall))
        else $error("input stalled with room in pipeline");

    // Weekday is a legal code whenever a result is presented
    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weekday <= 3'd6))
        else $error("weekday out of range");

    // Next year below the limit advances the year by exactly one
    a_next_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_NEXT_YEAR) && (r_held_year < YEAR_MAX))
        |=> (r_held_year == ($past(r_held_year) + 14'd1)))
        else $error("next year did not advance the year");

endmodule

`default_nettype wire
